// ----- hdl/three_axis_average_deadband_defines.svh -----
// Assertion macros shared by the three-axis average block.
`ifndef THREE_AXIS_AVERAGE_DEADBAND_DEFINES_SVH
`define THREE_AXIS_AVERAGE_DEADBAND_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication, sampled on clk, held off during reset
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- hdl/tadb_pkg.sv -----
// Package: sizes, register indexes and controller/datapath signal groups.
`default_nettype none
package tadb_pkg;

  localparam int DEPTH    = 5;
  localparam int AXIS_W   = 16;
  localparam int PERIOD_W = 16;
  localparam int THR_W    = 15;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam int SUM_W  = AXIS_W + $clog2(DEPTH) + 1;
  localparam int DCNT_W = $clog2(SUM_W);
  localparam int LANES  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_THRESHOLD = CFG_IDX_W'(1);

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(100);
  localparam logic [THR_W-1:0]    THR_RESET    = THR_W'(205);

  typedef struct packed {
    logic load;      // write sample into rings, restart summation
    logic sum_en;    // add one ring entry per lane
    logic div_init;  // load divider from sums
    logic div_en;    // one quotient bit per lane
    logic commit;    // latch means into sent and output registers
  } cmd_t;

  typedef struct packed {
    logic sum_last;
    logic div_last;
    logic moved;
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

// ----- hdl/tadb_if.sv -----
// Valid/ready channel interfaces for sample items and mean items.
`default_nettype none
interface tadb_in_if;
  logic                                valid;
  logic                                ready;
  logic                                sample_valid;
  logic signed [tadb_pkg::AXIS_W-1:0] accel_x;
  logic signed [tadb_pkg::AXIS_W-1:0] accel_y;
  logic signed [tadb_pkg::AXIS_W-1:0] accel_z;

  modport source (output valid, sample_valid, accel_x, accel_y, accel_z, input ready);
  modport sink   (input valid, sample_valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface tadb_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [tadb_pkg::AXIS_W-1:0] mean_x;
  logic signed [tadb_pkg::AXIS_W-1:0] mean_y;
  logic signed [tadb_pkg::AXIS_W-1:0] mean_z;

  modport source (output valid, mean_x, mean_y, mean_z, input ready);
  modport sink   (input valid, mean_x, mean_y, mean_z, output ready);
endinterface
`default_nettype wire

// ----- hdl/tadb_ctrl.sv -----
// Controller: tick counter, firing decision and sequencing of sum/divide/compare.
`default_nettype none
module tadb_ctrl (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_fire,
  input  wire logic                            sample_valid,
  input  wire logic [tadb_pkg::PERIOD_W-1:0]   sample_period,
  input  wire tadb_pkg::sts_t                  sts,
  output tadb_pkg::cmd_t                       cmd,
  output logic                                 in_ready
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SUM   = 3'd1;
  localparam logic [2:0] S_DINIT = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_CMP   = 3'd4;

  logic [2:0]                    state_r, state_nxt;
  logic [tadb_pkg::PERIOD_W-1:0] elapsed_r, elapsed_nxt, elapsed_inc;
  logic                          fire;

  // counter saturates at all ones; a period of zero fires every tick
  assign elapsed_inc = (elapsed_r == {tadb_pkg::PERIOD_W{1'b1}}) ? elapsed_r
                                                                  : elapsed_r + 1'b1;
  assign fire = (elapsed_inc >= sample_period);

  always_comb begin
    elapsed_nxt = elapsed_r;
    if (in_fire) begin
      elapsed_nxt = fire ? '0 : elapsed_inc;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire && fire && sample_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        cmd.sum_en = 1'b1;
        if (sts.sum_last) state_nxt = S_DINIT;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_en = 1'b1;
        if (sts.div_last) state_nxt = S_CMP;
      end
      S_CMP: begin
        if (!sts.moved) begin
          state_nxt = S_IDLE;
        end else if (!sts.out_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      elapsed_r <= '0;
    end else begin
      state_r   <= state_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/tadb_dp.sv -----
// Datapath: ring buffers, per-axis accumulators, bit-serial dividers, send-on-delta.
`default_nettype none
module tadb_dp (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire tadb_pkg::cmd_t                      cmd,
  output tadb_pkg::sts_t                           sts,
  input  wire logic signed [tadb_pkg::AXIS_W-1:0]  accel_x,
  input  wire logic signed [tadb_pkg::AXIS_W-1:0]  accel_y,
  input  wire logic signed [tadb_pkg::AXIS_W-1:0]  accel_z,
  input  wire logic [tadb_pkg::THR_W-1:0]          change_threshold,
  input  wire logic                                out_ready,
  output logic                                     out_valid,
  output logic signed [tadb_pkg::AXIS_W-1:0]       mean_x,
  output logic signed [tadb_pkg::AXIS_W-1:0]       mean_y,
  output logic signed [tadb_pkg::AXIS_W-1:0]       mean_z
);

  localparam int AW = tadb_pkg::AXIS_W;
  localparam int SW = tadb_pkg::SUM_W;
  localparam int FW = tadb_pkg::FILL_W;
  localparam int NL = tadb_pkg::LANES;

  logic signed [AW-1:0]          ring_r [NL][tadb_pkg::DEPTH];
  logic [tadb_pkg::SLOT_W-1:0]   slot_r, idx_r, slot_inc;
  logic [FW-1:0]                 fill_r;
  logic [tadb_pkg::DCNT_W-1:0]   dcnt_r;
  logic                          has_sent_r, out_valid_r;

  logic signed [SW-1:0]          acc_r  [NL];
  logic [SW-1:0]                 quo_r  [NL];
  logic [FW-1:0]                 rem_r  [NL];
  logic                          neg_r  [NL];
  logic signed [AW-1:0]          sent_r [NL];
  logic signed [AW-1:0]          omean_r[NL];

  logic signed [AW-1:0]          smp    [NL];
  logic [FW:0]                   trial  [NL];
  logic                          ge     [NL];
  logic signed [AW-1:0]          mean   [NL];
  logic signed [AW:0]            diff   [NL];
  logic [AW:0]                   adiff  [NL];
  logic                          over   [NL];

  assign smp[0] = accel_x;
  assign smp[1] = accel_y;
  assign smp[2] = accel_z;

  assign slot_inc = (slot_r == tadb_pkg::SLOT_W'(tadb_pkg::DEPTH - 1)) ? '0 : slot_r + 1'b1;

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      // restoring step: remainder stays below the fill count
      trial[l] = {rem_r[l], quo_r[l][SW-1]};
      ge[l]    = (trial[l] >= {1'b0, fill_r});
      // quotient magnitude fits 16 bits, low bits negate exactly
      mean[l]  = neg_r[l] ? -$signed(quo_r[l][AW-1:0]) : $signed(quo_r[l][AW-1:0]);
      diff[l]  = (AW+1)'(mean[l]) - (AW+1)'(sent_r[l]);
      adiff[l] = diff[l][AW] ? (AW+1)'(-diff[l]) : (AW+1)'(diff[l]);
      over[l]  = (adiff[l] > {2'b00, change_threshold});
    end
  end

  assign sts.sum_last = ((FW'(idx_r) + FW'(1)) == fill_r);
  assign sts.div_last = (dcnt_r == '0);
  assign sts.moved    = !has_sent_r || over[0] || over[1] || over[2];
  assign sts.out_busy = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= '0;
      fill_r      <= '0;
      idx_r       <= '0;
      dcnt_r      <= '0;
      has_sent_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        slot_r <= slot_inc;
        idx_r  <= '0;
        if (fill_r != FW'(tadb_pkg::DEPTH)) fill_r <= fill_r + 1'b1;
      end
      if (cmd.sum_en)   idx_r  <= idx_r + 1'b1;
      if (cmd.div_init) dcnt_r <= tadb_pkg::DCNT_W'(SW - 1);
      if (cmd.div_en)   dcnt_r <= dcnt_r - 1'b1;
      if (cmd.commit) begin
        has_sent_r  <= 1'b1;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset; ring entries are read only once written
  always_ff @(posedge clk) begin
    for (int l = 0; l < NL; l++) begin
      if (cmd.load) begin
        ring_r[l][slot_r] <= smp[l];
        acc_r[l]          <= '0;
      end
      if (cmd.sum_en) acc_r[l] <= acc_r[l] + SW'(ring_r[l][idx_r]);
      if (cmd.div_init) begin
        neg_r[l] <= acc_r[l][SW-1];
        quo_r[l] <= acc_r[l][SW-1] ? SW'(-acc_r[l]) : SW'(acc_r[l]);
        rem_r[l] <= '0;
      end
      if (cmd.div_en) begin
        rem_r[l] <= ge[l] ? FW'(trial[l] - {1'b0, fill_r}) : trial[l][FW-1:0];
        quo_r[l] <= {quo_r[l][SW-2:0], ge[l]};
      end
      if (cmd.commit) begin
        sent_r[l]  <= mean[l];
        omean_r[l] <= mean[l];
      end
    end
  end

  // sent means have no reset; only read once has_sent is set
  assign out_valid = out_valid_r;
  assign mean_x    = omean_r[0];
  assign mean_y    = omean_r[1];
  assign mean_z    = omean_r[2];

endmodule
`default_nettype wire

// ----- hdl/three_axis_average_deadband.sv -----
// An item that does not fire the period counter, or fires with an invalid sample, is
// finished when it is taken in IDLE. A firing valid item passes IDLE (load), SUM (one
// ring entry per filled slot), DINIT, the 20-step bit-serial DIV and CMP; CMP holds a
// new mean item while the previous one is unaccepted. One item is in work at a time.
// Reset (synchronous, rst_n low): counters, fill count and sent flag clear, sample_period
// returns to 100 and change_threshold to 205; no clearing pass.
`default_nettype none
`include "three_axis_average_deadband_defines.svh"
module three_axis_average_deadband (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  tadb_in_if.sink                                  in_ch,
  tadb_out_if.source                               out_ch,
  input  wire logic                                cfg_we,
  input  wire logic [tadb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [tadb_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic [tadb_pkg::PERIOD_W-1:0] sample_period_r;
  logic [tadb_pkg::THR_W-1:0]    change_threshold_r;
  tadb_pkg::cmd_t                cmd;
  tadb_pkg::sts_t                sts;
  logic                          in_ready;
  logic                          in_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_period_r    <= tadb_pkg::PERIOD_RESET;
      change_threshold_r <= tadb_pkg::THR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tadb_pkg::CFG_SAMPLE_PERIOD:    sample_period_r    <= cfg_wdata[tadb_pkg::PERIOD_W-1:0];
        tadb_pkg::CFG_CHANGE_THRESHOLD: change_threshold_r <= cfg_wdata[tadb_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = in_ready;
  assign in_fire     = in_ch.valid && in_ready;

  tadb_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_fire       (in_fire),
    .sample_valid  (in_ch.sample_valid),
    .sample_period (sample_period_r),
    .sts           (sts),
    .cmd           (cmd),
    .in_ready      (in_ready)
  );

  tadb_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .accel_x          (in_ch.accel_x),
    .accel_y          (in_ch.accel_y),
    .accel_z          (in_ch.accel_z),
    .change_threshold (change_threshold_r),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .mean_x           (out_ch.mean_x),
    .mean_y           (out_ch.mean_y),
    .mean_z           (out_ch.mean_z)
  );

  `ASSERT_NEXT(a_load_blocks_input, cmd.load, !in_ch.ready)
  `ASSERT_IMP(a_commit_into_free_slot, cmd.commit, !sts.out_busy)
  `ASSERT_IMP(a_sum_div_exclusive, cmd.sum_en, !cmd.div_en && !in_ch.ready)
  `ASSERT_NEXT(a_commit_shows_item, cmd.commit, out_ch.valid)

endmodule
`default_nettype wire

// ----- tb/tb_three_axis_average_deadband.sv -----
// Self-checking testbench for the three-axis moving average with send-on-delta output.
module tb_three_axis_average_deadband;
  timeunit 1ns;
  timeprecision 1ps;
  import tadb_pkg::*;

  localparam int AXIS_MAX     = 2 ** (AXIS_W - 1) - 1;
  localparam int AXIS_MIN     = -(2 ** (AXIS_W - 1));
  localparam int TICK_MAX     = 2 ** PERIOD_W - 1;
  localparam int RANDOM_ITEMS = 1200;
  localparam int LONG_RUN     = 160;
  localparam int SETTLE       = 40;   // time for a firing item to pass through the states
  localparam int LONG_HOLD    = 400;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = '1;

  typedef struct packed {
    logic                     sample_valid;
    logic signed [AXIS_W-1:0] accel_x;
    logic signed [AXIS_W-1:0] accel_y;
    logic signed [AXIS_W-1:0] accel_z;
  } accel_item_t;

  typedef struct packed {
    logic signed [AXIS_W-1:0] mean_x;
    logic signed [AXIS_W-1:0] mean_y;
    logic signed [AXIS_W-1:0] mean_z;
  } mean_item_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tadb_in_if  in_ch();
  tadb_out_if out_ch();

  three_axis_average_deadband dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state and register copies
  logic signed [AXIS_W-1:0] ring_mem [3][DEPTH];
  logic signed [AXIS_W-1:0] last_sent [3];
  bit has_sent;
  int slot, filled, ticks;
  int period_cfg, thr_cfg;

  accel_item_t sample_q[$];
  mean_item_t  mean_q[$];

  int errors = 0;
  int fired = 0;
  int checked = 0;
  int settings = 0;
  bit no_gap = 1'b0;
  bit hold_wanted = 1'b0;
  int drift [3];

  logic in_took, out_took;
  int in_gap = 0, out_wait = 0, hold_left = 0;
  bit in_flow = 1'b0, out_flow = 1'b0, hold_done = 1'b0;

  function automatic bit average_step(input accel_item_t it, output mean_item_t m);
    int sum [3];
    int mean [3];
    int diff;
    bit go;
    m = '0;
    go = !has_sent;
    if (ticks < TICK_MAX) ticks++;
    if (ticks < period_cfg) return 1'b0;
    ticks = 0;
    if (!it.sample_valid) return 1'b0;
    fired++;
    if (slot >= DEPTH) slot = 0;
    ring_mem[0][slot] = it.accel_x;
    ring_mem[1][slot] = it.accel_y;
    ring_mem[2][slot] = it.accel_z;
    slot = (slot + 1 >= DEPTH) ? 0 : slot + 1;
    if (filled < DEPTH) filled++;
    for (int a = 0; a < 3; a++) begin
      sum[a] = 0;
      for (int i = 0; i < filled; i++) sum[a] += ring_mem[a][i];
      mean[a] = sum[a] / filled;  // int division truncates toward zero
      diff = mean[a] - int'(last_sent[a]);
      if (diff < 0) diff = -diff;
      if (diff > thr_cfg) go = 1'b1;
    end
    if (!go) return 1'b0;
    for (int a = 0; a < 3; a++) last_sent[a] = mean[a][AXIS_W-1:0];
    has_sent = 1'b1;
    m.mean_x = mean[0][AXIS_W-1:0];
    m.mean_y = mean[1][AXIS_W-1:0];
    m.mean_z = mean[2][AXIS_W-1:0];
    return 1'b1;
  endfunction

  function automatic logic signed [AXIS_W-1:0] clamp_axis(int v);
    if (v > AXIS_MAX) return AXIS_MAX[AXIS_W-1:0];
    if (v < AXIS_MIN) return AXIS_MIN[AXIS_W-1:0];
    return v[AXIS_W-1:0];
  endfunction

  // mostly a slowly drifting signal with noise, some full-range and extreme items
  function automatic accel_item_t next_sample(int spread);
    accel_item_t it;
    logic signed [AXIS_W-1:0] v [3];
    int pick;
    pick = $urandom_range(0, 99);
    for (int a = 0; a < 3; a++) begin
      if (pick < 8) begin
        v[a] = AXIS_W'($urandom);
      end else if (pick < 12) begin
        v[a] = $urandom_range(0, 1) ? AXIS_MAX[AXIS_W-1:0] : AXIS_MIN[AXIS_W-1:0];
      end else begin
        if ($urandom_range(0, 49) == 0) drift[a] = $urandom_range(0, 65535) + AXIS_MIN;
        else drift[a] = clamp_axis(drift[a] + $urandom_range(0, 200) - 100);
        v[a] = clamp_axis(drift[a] + $urandom_range(0, 2 * spread) - spread);
      end
    end
    it.sample_valid = ($urandom_range(0, 99) < 85);
    it.accel_x = v[0];
    it.accel_y = v[1];
    it.accel_z = v[2];
    return it;
  endfunction

  task automatic check_axis(string name, logic signed [AXIS_W-1:0] want,
                            logic signed [AXIS_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  task automatic queue_sample(logic v, int x, int y, int z);
    accel_item_t it;
    it.sample_valid = v;
    it.accel_x = x[AXIS_W-1:0];
    it.accel_y = y[AXIS_W-1:0];
    it.accel_z = z[AXIS_W-1:0];
    sample_q.push_back(it);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SAMPLE_PERIOD:    period_cfg = val;
      CFG_CHANGE_THRESHOLD: thr_cfg = val[THR_W-1:0];
      default: ;
    endcase
    settings++;
  endtask

  // idle: every item accepted, every mean item back, then time for a silent item to finish
  task automatic wait_idle();
    do @(posedge clk); while (sample_q.size() != 0 || in_ch.valid || mean_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // acceptance on both channels
  always @(posedge clk) begin
    accel_item_t it;
    mean_item_t want, got;
    if (!rst_n) begin
      in_took  <= 1'b0;
      out_took <= 1'b0;
    end else begin
      in_took  <= in_ch.valid && in_ch.ready;
      out_took <= out_ch.valid && out_ch.ready;
      if (out_ch.valid && out_ch.ready) begin
        got.mean_x = out_ch.mean_x;
        got.mean_y = out_ch.mean_y;
        got.mean_z = out_ch.mean_z;
        if (mean_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected mean item, expected none, actual %0d %0d %0d",
                   $time, got.mean_x, got.mean_y, got.mean_z);
        end else begin
          want = mean_q.pop_front();
          check_axis("mean_x", want.mean_x, got.mean_x);
          check_axis("mean_y", want.mean_y, got.mean_y);
          check_axis("mean_z", want.mean_z, got.mean_z);
          checked++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        it.sample_valid = in_ch.sample_valid;
        it.accel_x = in_ch.accel_x;
        it.accel_y = in_ch.accel_y;
        it.accel_z = in_ch.accel_z;
        if (average_step(it, want)) mean_q.push_back(want);
      end
    end
  end

  // sample driver
  always @(negedge clk) begin
    accel_item_t it;
    if (rst_n && (!in_ch.valid || in_took)) begin
      if (in_gap == 0 && sample_q.size() != 0) begin
        it = sample_q.pop_front();
        in_ch.sample_valid <= it.sample_valid;
        in_ch.accel_x      <= it.accel_x;
        in_ch.accel_y      <= it.accel_y;
        in_ch.accel_z      <= it.accel_z;
        in_ch.valid        <= 1'b1;
        if ($urandom_range(0, 39) == 0) in_flow = !in_flow;
        in_gap = (in_flow || no_gap) ? 0 : $urandom_range(0, 19);
      end else begin
        in_ch.valid <= 1'b0;
        if (in_gap != 0) in_gap--;
      end
    end
  end

  // mean receiver, with one long hold-off to back up the block
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_wanted && !hold_done) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (out_took) begin
        if ($urandom_range(0, 39) == 0) out_flow = !out_flow;
        out_wait = out_flow ? 0 : $urandom_range(0, 19);
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (out_wait != 0) begin
        out_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int n_random;
    int phase;
    int cnt;
    int spread;
    int pick;
    logic [CFG_DATA_W-1:0] per, thr;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.sample_valid = 1'b0;
    in_ch.accel_x = '0;
    in_ch.accel_y = '0;
    in_ch.accel_z = '0;
    out_ch.ready = 1'b0;
    period_cfg = PERIOD_RESET;
    thr_cfg = THR_RESET;
    for (int a = 0; a < 3; a++) begin
      for (int i = 0; i < DEPTH; i++) ring_mem[a][i] = '0;
      last_sent[a] = '0;
      drift[a] = 0;
    end
    has_sent = 1'b0;
    slot = 0;
    filled = 0;
    ticks = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: these only advance the period counter
    @(posedge clk);
    queue_sample(1'b1, AXIS_MAX, AXIS_MIN, 0);
    queue_sample(1'b1, AXIS_MIN, AXIS_MAX, -1);
    wait_idle();

    // every tick fires, any change is sent
    write_reg(CFG_SAMPLE_PERIOD, 1);
    write_reg(CFG_CHANGE_THRESHOLD, 0);
    @(posedge clk);
    queue_sample(1'b1, AXIS_MAX, AXIS_MIN, 0);   // first item is always sent
    queue_sample(1'b1, AXIS_MAX, AXIS_MIN, 0);   // equal means stay silent
    queue_sample(1'b0, AXIS_MIN, AXIS_MAX, -1);  // invalid on a firing tick
    queue_sample(1'b1, AXIS_MIN, AXIS_MAX, -1);
    queue_sample(1'b1, -1, -1, -1);
    queue_sample(1'b1, -1, 1, -3);
    queue_sample(1'b1, 3, -2, 1);                // ring already full, oldest slot overwritten
    queue_sample(1'b1, -7, 7, 2);                // oldest slot overwritten
    queue_sample(1'b1, 1, 1, 1);
    wait_idle();

    // index past the register list is dropped
    write_reg(CFG_UNMAPPED, 16'h0007);
    write_reg(CFG_SAMPLE_PERIOD, 0);
    @(posedge clk);
    queue_sample(1'b1, 100, -100, 50);
    queue_sample(1'b0, 200, 300, 400);
    queue_sample(1'b1, -100, 100, -50);
    wait_idle();

    // upper bit of the data is dropped, giving the widest dead band
    write_reg(CFG_CHANGE_THRESHOLD, 16'hFFFF);
    @(posedge clk);
    repeat (3) queue_sample(1'b1, AXIS_MIN, AXIS_MIN, AXIS_MAX);
    repeat (3) queue_sample(1'b1, AXIS_MAX, AXIS_MAX, AXIS_MIN);
    wait_idle();

    n_random = 0;
    phase = 0;
    while (n_random < RANDOM_ITEMS) begin
      phase++;
      pick = $urandom_range(0, 9);
      if (pick == 0) per = 0;
      else if (pick < 5) per = 1;
      else if (pick < 7) per = $urandom_range(2, 3);
      else if (pick < 9) per = $urandom_range(4, 12);
      else per = ($urandom_range(0, 2) == 0) ? PERIOD_RESET : 1;
      pick = $urandom_range(0, 7);
      if (pick == 0) thr = 0;
      else if (pick == 1) thr = 2 ** THR_W - 1;
      else if (pick == 2) thr = THR_RESET;
      else thr = $urandom_range(0, 1500);
      spread = $urandom_range(0, 2000);
      if (phase == 3) begin
        per = 1;
        thr = 0;
        spread = 4000;
      end
      write_reg(CFG_SAMPLE_PERIOD, per);
      if (phase < 4 || $urandom_range(0, 3) != 0) write_reg(CFG_CHANGE_THRESHOLD, thr);
      @(posedge clk);
      if (phase == 3) hold_wanted = 1'b1;
      cnt = $urandom_range(40, 160);
      repeat (cnt) sample_q.push_back(next_sample(spread));
      n_random += cnt;
      wait_idle();
    end

    // longest period stays silent, then a long period, both fed back to back
    write_reg(CFG_SAMPLE_PERIOD, 2 ** PERIOD_W - 1);
    write_reg(CFG_CHANGE_THRESHOLD, $urandom_range(0, 1500));
    @(posedge clk);
    no_gap = 1'b1;
    repeat (LONG_RUN) sample_q.push_back(next_sample(1000));
    wait_idle();
    write_reg(CFG_SAMPLE_PERIOD, 150);
    @(posedge clk);
    repeat (2 * LONG_RUN) sample_q.push_back(next_sample(1000));
    wait_idle();
    no_gap = 1'b0;

    if (mean_q.size() != 0) begin
      errors++;
      $display("%0t: %0d mean items expected, actual none", $time, mean_q.size());
    end
    $display("%0d random samples plus directed and long-period runs, %0d register writes",
             n_random, settings);
    $display("%0d samples entered the rings, %0d mean items checked, %0d mismatches",
             fired, checked, errors);
    if (errors == 0) $display("tb_three_axis_average_deadband OK");
    else $display("tb_three_axis_average_deadband NOT OK");
    $finish;
  end

  initial begin
    #12_000_000;
    $display("tb_three_axis_average_deadband NOT OK");
    $finish;
  end

endmodule
